>>> hw/rtl/ddo_pkg.sv
// Shared constants, codes and helper functions for the differential-drive odometry block.
package ddo_pkg;

    localparam int INTERVAL_WIDTH = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam int STEP_W         = $clog2(CORDIC_STEPS);
    localparam int ARC_IDX_W      = 5;

    localparam int CMD_W     = 2;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_LEFT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RIGHT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PER_TICK = 1'b1;

    localparam logic [CFG_W-1:0] MM_PER_TICK_RESET    = 24'd257359;
    localparam logic [CFG_W-1:0] ANGLE_PER_TICK_RESET = 24'd104858;

    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0] RUN_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] RUN_MIN  = 32'sh8000_0000;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // arctan(2^-i) in units of 2^32 per turn
    function automatic logic [31:0] arc_angle(input logic [ARC_IDX_W-1:0] idx);
        logic [31:0] a;
        unique case (idx)
            5'd0:    a = 32'h2000_0000;
            5'd1:    a = 32'h12E4_051D;
            5'd2:    a = 32'h09FB_385B;
            5'd3:    a = 32'h0511_11D4;
            5'd4:    a = 32'h028B_0D43;
            5'd5:    a = 32'h0145_D7E1;
            5'd6:    a = 32'h00A2_F61E;
            5'd7:    a = 32'h0051_7C55;
            5'd8:    a = 32'h0028_BE53;
            5'd9:    a = 32'h0014_5F2E;
            5'd10:   a = 32'h000A_2F98;
            5'd11:   a = 32'h0005_17CC;
            5'd12:   a = 32'h0002_8BE6;
            5'd13:   a = 32'h0001_45F3;
            5'd14:   a = 32'h0000_A2F9;
            5'd15:   a = 32'h0000_517C;
            5'd16:   a = 32'h0000_28BE;
            5'd17:   a = 32'h0000_145F;
            5'd18:   a = 32'h0000_0A2F;
            5'd19:   a = 32'h0000_0517;
            5'd20:   a = 32'h0000_028B;
            5'd21:   a = 32'h0000_0145;
            5'd22:   a = 32'h0000_00A2;
            5'd23:   a = 32'h0000_0051;
            default: a = 32'h0000_0000;
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > SAT_MAX)
            return RUN_MAX;
        else if (v < SAT_MIN)
            return RUN_MIN;
        return v[31:0];
    endfunction

endpackage

>>> hw/rtl/ddo_if.sv
// Request and pose channel interfaces for the differential-drive odometry block.
interface ddo_cmd_if import ddo_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic             speed_positive;

    modport source (output valid, command, speed_positive, input ready);
    modport sink   (input valid, command, speed_positive, output ready);
endinterface

interface ddo_pose_if import ddo_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] left_total;
    logic signed [31:0] right_total;

    modport source (output valid, pos_x, pos_y, heading, left_total, right_total, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, left_total, right_total, output ready);
endinterface

>>> hw/rtl/differential_drive_odometry.sv
// Differential-drive wheel odometry: tick counting, pose update via shared multiplier and CORDIC.
// A wheel tick request is taken whenever the block is idle and gives no pose. An update request
// holds cmd.ready low until its pose is loaded: it forms the angle and distance products, runs
// the CORDIC rotation through the single shift-add rotator, forms the x and y products on the
// same 33x32 multiplier, and then rounds, saturates and loads the pose register. The finished
// pose waits in its own register, so ticks are taken again while it is still unread; a further
// update holds in its final state until that pose is read.
// Command 3 is dropped; configuration must be written through cfg_we, cfg_index and cfg_data
// only between requests, with no update under way; the block itself does not enforce this.
module differential_drive_odometry import ddo_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    ddo_cmd_if.sink              cmd,
    ddo_pose_if.source           pose,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int IV_W     = INTERVAL_WIDTH;
    localparam int IV_SUM_W = INTERVAL_WIDTH + 1;
    localparam int XY_W     = 34;
    localparam int Z_W      = 33;

    localparam logic signed [IV_W-1:0] IV_MAX = {1'b0, {(IV_W-1){1'b1}}};
    localparam logic signed [IV_W-1:0] IV_MIN = {1'b1, {(IV_W-1){1'b0}}};
    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ANG  = 9'b000000010,
        S_DIST = 9'b000000100,
        S_PREP = 9'b000001000,
        S_ROT  = 9'b000010000,
        S_MULX = 9'b000100000,
        S_MULY = 9'b001000000,
        S_ACCY = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] mm_per_tick_reg, angle_per_tick_reg;

    logic signed [IV_W-1:0] left_iv_reg, left_iv_next;
    logic signed [IV_W-1:0] right_iv_reg, right_iv_next;
    logic signed [31:0]     left_run_reg, left_run_next;
    logic signed [31:0]     right_run_reg, right_run_next;
    logic signed [31:0]     x_acc_reg, x_acc_next;
    logic signed [31:0]     y_acc_reg, y_acc_next;
    logic [15:0]            heading_reg, heading_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;

    logic signed [64:0]     prod_reg;
    logic signed [IV_W-1:0] half_reg, half_next;
    logic signed [31:0]     dist_reg, dist_next;
    logic signed [XY_W-1:0] cx_reg, cx_next;
    logic signed [XY_W-1:0] cy_reg, cy_next;
    logic signed [Z_W-1:0]  cz_reg, cz_next;
    logic                   flip_reg, flip_next;
    logic signed [31:0]     px_reg, py_reg, pl_reg, pr_reg;
    logic [15:0]            ph_reg;
    logic                   load_pose;

    logic                       cmd_fire;
    logic signed [IV_SUM_W-1:0] iv_diff, iv_sum, iv_sum_adj;
    logic signed [32:0]         mul_a;
    logic signed [31:0]         mul_b;
    logic signed [64:0]         product;
    logic [23:0]                ang_rnd;
    logic signed [64:0]         dist_rnd;
    logic signed [64:0]         acc_rnd;
    logic signed [34:0]         acc_delta;
    logic signed [31:0]         cos_val, sin_val;
    logic signed [XY_W-1:0]     cx_sh, cy_sh;
    logic signed [Z_W-1:0]      arc_val;
    logic [31:0]                hz, hz_rot;
    logic                       hz_flip;

    assign cmd_fire   = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);

    assign iv_diff    = IV_SUM_W'(right_iv_reg) - IV_SUM_W'(left_iv_reg);
    assign iv_sum     = IV_SUM_W'(right_iv_reg) + IV_SUM_W'(left_iv_reg);
    // toward-zero halving: bias negatives by one before the floor shift
    assign iv_sum_adj = iv_sum + $signed({{(IV_SUM_W-1){1'b0}}, iv_sum[IV_SUM_W-1]});

    assign ang_rnd    = prod_reg[23:0] + 24'd128;
    assign dist_rnd   = prod_reg + 65'sd128;
    assign acc_rnd    = prod_reg + (65'sd1 <<< 29);
    assign acc_delta  = $signed(acc_rnd[64:30]);

    assign cos_val    = flip_reg ? 32'(-cx_reg) : 32'(cx_reg);
    assign sin_val    = flip_reg ? 32'(-cy_reg) : 32'(cy_reg);

    assign cx_sh      = cx_reg >>> step_reg;
    assign cy_sh      = cy_reg >>> step_reg;
    assign arc_val    = $signed({1'b0, arc_angle(ARC_IDX_W'(step_reg))});

    assign hz         = {heading_reg, 16'h0000};
    assign hz_flip    = hz[31] ^ hz[30];
    assign hz_rot     = hz_flip ? {~hz[31], hz[30:0]} : hz;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_ANG:
            begin
                mul_a = 33'(iv_diff);
                mul_b = $signed({8'h00, angle_per_tick_reg});
            end
            S_DIST:
            begin
                mul_a = 33'(half_reg);
                mul_b = $signed({8'h00, mm_per_tick_reg});
            end
            S_MULX:
            begin
                mul_a = 33'(dist_reg);
                mul_b = cos_val;
            end
            S_MULY:
            begin
                mul_a = 33'(dist_reg);
                mul_b = sin_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    always_comb
    begin
        state_next     = state_reg;
        left_iv_next   = left_iv_reg;
        right_iv_next  = right_iv_reg;
        left_run_next  = left_run_reg;
        right_run_next = right_run_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        heading_next   = heading_reg;
        step_next      = step_reg;
        half_next      = half_reg;
        dist_next      = dist_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        load_pose      = 1'b0;
        out_valid_next = out_valid_reg;

        if (pose.valid && pose.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    priority if (cmd.command == CMD_LEFT)
                    begin
                        if (cmd.speed_positive)
                        begin
                            if (left_iv_reg != IV_MAX)
                                left_iv_next = left_iv_reg + IV_W'(1);
                            if (left_run_reg != RUN_MAX)
                                left_run_next = left_run_reg + 32'sd1;
                        end
                        else
                        begin
                            if (left_iv_reg != IV_MIN)
                                left_iv_next = left_iv_reg - IV_W'(1);
                            if (left_run_reg != RUN_MIN)
                                left_run_next = left_run_reg - 32'sd1;
                        end
                    end
                    else if (cmd.command == CMD_RIGHT)
                    begin
                        if (cmd.speed_positive)
                        begin
                            if (right_iv_reg != IV_MAX)
                                right_iv_next = right_iv_reg + IV_W'(1);
                            if (right_run_reg != RUN_MAX)
                                right_run_next = right_run_reg + 32'sd1;
                        end
                        else
                        begin
                            if (right_iv_reg != IV_MIN)
                                right_iv_next = right_iv_reg - IV_W'(1);
                            if (right_run_reg != RUN_MIN)
                                right_run_next = right_run_reg - 32'sd1;
                        end
                    end
                    else if (cmd.command == CMD_UPDATE)
                    begin
                        state_next = S_ANG;
                    end
                    else
                    begin
                        // unused command: dropped
                    end
                end
            end
            S_ANG:
            begin
                half_next     = iv_sum_adj[IV_SUM_W-1:1];
                left_iv_next  = '0;
                right_iv_next = '0;
                state_next    = S_DIST;
            end
            S_DIST:
            begin
                heading_next = heading_reg + ang_rnd[23:8];
                state_next   = S_PREP;
            end
            S_PREP:
            begin
                dist_next  = sat32(66'($signed(dist_rnd[64:8])));
                cx_next    = XY_W'(GAIN_Q30);
                cy_next    = '0;
                cz_next    = Z_W'($signed(hz_rot));
                flip_next  = hz_flip;
                step_next  = '0;
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (!cz_reg[Z_W-1])
                begin
                    cx_next = cx_reg - cy_sh;
                    cy_next = cy_reg + cx_sh;
                    cz_next = cz_reg - arc_val;
                end
                else
                begin
                    cx_next = cx_reg + cy_sh;
                    cy_next = cy_reg - cx_sh;
                    cz_next = cz_reg + arc_val;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                    state_next = S_MULX;
            end
            S_MULX:
            begin
                state_next = S_MULY;
            end
            S_MULY:
            begin
                x_acc_next = sat32(66'(x_acc_reg) + 66'(acc_delta));
                state_next = S_ACCY;
            end
            S_ACCY:
            begin
                y_acc_next = sat32(66'(y_acc_reg) + 66'(acc_delta));
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || pose.ready)
                begin
                    load_pose      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            left_iv_reg   <= '0;
            right_iv_reg  <= '0;
            left_run_reg  <= '0;
            right_run_reg <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            heading_reg   <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_iv_reg   <= left_iv_next;
            right_iv_reg  <= right_iv_next;
            left_run_reg  <= left_run_next;
            right_run_reg <= right_run_next;
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            heading_reg   <= heading_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_per_tick_reg    <= MM_PER_TICK_RESET;
            angle_per_tick_reg <= ANGLE_PER_TICK_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MM_PER_TICK)
                mm_per_tick_reg <= cfg_data;
            else if (cfg_index == REG_ANGLE_PER_TICK)
                angle_per_tick_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        half_reg <= half_next;
        dist_reg <= dist_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        flip_reg <= flip_next;
        if (load_pose)
        begin
            px_reg <= x_acc_reg;
            py_reg <= y_acc_reg;
            ph_reg <= heading_reg;
            pl_reg <= left_run_reg;
            pr_reg <= right_run_reg;
        end
    end

    assign pose.valid       = out_valid_reg;
    assign pose.pos_x       = px_reg;
    assign pose.pos_y       = py_reg;
    assign pose.heading     = $signed(ph_reg);
    assign pose.left_total  = pl_reg;
    assign pose.right_total = pr_reg;

`ifndef SYNTH
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_update_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (cmd.command == CMD_UPDATE) |=> state_reg == S_ANG)
        else $error("update request did not start the sequence");

    a_interval_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ANG |=> (left_iv_reg == '0) && (right_iv_reg == '0))
        else $error("interval counters not cleared by update");

    a_rot_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PREP |=> (state_reg == S_ROT) && (step_reg == '0))
        else $error("rotation did not start at step zero");

    a_pose_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load_pose |-> (!out_valid_reg || pose.ready))
        else $error("pose overwritten while unread");
`endif

endmodule

>>> dv/differential_drive_odometry_test.sv
// Self-checking testbench for the differential-drive odometry block: tick and update requests.
`timescale 1ns / 1ps

module differential_drive_odometry_test import ddo_pkg::*; ();

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [31:0] left_total;
        logic signed [31:0] right_total;
    } pose_t;

    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam longint SUM_MAX   = 64'sd2147483647;
    localparam longint SUM_MIN   = -64'sd2147483648;
    localparam longint UNIT_GAIN = 64'sd652032874;
    localparam int     SETTLE    = 30;
    localparam int     PHASE_LEN = 220;

    // arctan(2^-i), 2^32 per turn
    localparam logic [31:0] ARC_TURNS [0:23] = '{
        32'h2000_0000, 32'h12E4_051D, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2E,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9,
        32'h0000_517C, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
        32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ddo_cmd_if  request_ch ();
    ddo_pose_if pose_ch ();

    differential_drive_odometry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (request_ch),
        .pose      (pose_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // odometry state as the block should hold it
    logic [CFG_W-1:0]                 mm_setting    = MM_PER_TICK_RESET;
    logic [CFG_W-1:0]                 angle_setting = ANGLE_PER_TICK_RESET;
    logic signed [INTERVAL_WIDTH-1:0] left_ticks    = '0;
    logic signed [INTERVAL_WIDTH-1:0] right_ticks   = '0;
    logic signed [31:0]               left_sum      = '0;
    logic signed [31:0]               right_sum     = '0;
    logic signed [31:0]               x_mm          = '0;
    logic signed [31:0]               y_mm          = '0;
    logic [15:0]                      heading_ba    = '0;

    pose_t poses_due [$];
    int    faults  = 0;
    bit    no_gaps = 1'b0;

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint round_down_by(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic void cordic_cos_sin(input logic [15:0] angle, output longint c,
                                           output longint s);
        logic [31:0] z;
        logic        flip;
        longint      zs;
        longint      xv;
        longint      yv;
        longint      xs;
        longint      ys;
        z    = {angle, 16'h0000};
        flip = z[31] ^ z[30];
        if (flip)
            z = z - 32'h8000_0000;
        zs = longint'($signed(z));
        xv = UNIT_GAIN;
        yv = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (zs >= 0)
            begin
                xv = xv - ys;
                yv = yv + xs;
                zs = zs - longint'(ARC_TURNS[i]);
            end
            else
            begin
                xv = xv + ys;
                yv = yv - xs;
                zs = zs + longint'(ARC_TURNS[i]);
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endfunction

    task automatic advance_odometry(input logic [CMD_W-1:0] command, input logic speed);
        longint step;
        longint imax;
        longint diff;
        longint half;
        longint dth;
        longint travel;
        longint c;
        longint s;
        pose_t  p;
        step = speed ? 64'sd1 : -64'sd1;
        imax = (longint'(1) << (INTERVAL_WIDTH - 1)) - 1;
        case (command)
            CMD_LEFT:
            begin
                left_ticks = INTERVAL_WIDTH'(clamp_to(longint'(left_ticks) + step,
                                                      -imax - 1, imax));
                left_sum   = 32'(clamp_to(longint'(left_sum) + step, SUM_MIN, SUM_MAX));
            end
            CMD_RIGHT:
            begin
                right_ticks = INTERVAL_WIDTH'(clamp_to(longint'(right_ticks) + step,
                                                       -imax - 1, imax));
                right_sum   = 32'(clamp_to(longint'(right_sum) + step, SUM_MIN, SUM_MAX));
            end
            CMD_UPDATE:
            begin
                diff   = longint'(right_ticks) - longint'(left_ticks);
                half   = (longint'(right_ticks) + longint'(left_ticks)) / 2;
                dth    = round_down_by(diff * longint'(angle_setting), 8);
                travel = clamp_to(round_down_by(half * longint'(mm_setting), 8),
                                  SUM_MIN, SUM_MAX);
                left_ticks  = '0;
                right_ticks = '0;
                heading_ba  = heading_ba + dth[15:0];
                cordic_cos_sin(heading_ba, c, s);
                x_mm = 32'(clamp_to(longint'(x_mm) + round_down_by(travel * c, 30),
                                    SUM_MIN, SUM_MAX));
                y_mm = 32'(clamp_to(longint'(y_mm) + round_down_by(travel * s, 30),
                                    SUM_MIN, SUM_MAX));
                p.pos_x       = x_mm;
                p.pos_y       = y_mm;
                p.heading     = heading_ba;
                p.left_total  = left_sum;
                p.right_total = right_sum;
                poses_due.push_back(p);
            end
            default:
            begin
            end
        endcase
    endtask

    // one request; starts and ends at a falling edge
    task automatic send_request(input logic [CMD_W-1:0] command, input logic speed);
        while (!no_gaps && $urandom_range(0, 2) == 0)
        begin
            request_ch.valid = 1'b0;
            @(negedge clk);
        end
        request_ch.valid          = 1'b1;
        request_ch.command        = command;
        request_ch.speed_positive = speed;
        @(posedge clk);
        while (!request_ch.ready)
            @(posedge clk);
        advance_odometry(command, speed);
        @(negedge clk);
        request_ch.valid = 1'b0;
    endtask

    task automatic wait_for_poses;
        while (poses_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] mm, input logic [CFG_W-1:0] angle);
        wait_for_poses;
        write_register(REG_MM_PER_TICK, mm);
        mm_setting = mm;
        write_register(REG_ANGLE_PER_TICK, angle);
        angle_setting = angle;
    endtask

    task automatic tick_both(input int n, input logic up);
        repeat (n) send_request(CMD_LEFT, up);
        repeat (n) send_request(CMD_RIGHT, up);
        send_request(CMD_UPDATE, 1'b1);
    endtask

    // long straight runs at the largest travel per tick, with no idling on either side
    task automatic test_long_runs;
        configure(24'hFF_FFFF, ANGLE_PER_TICK_RESET);
        no_gaps = 1'b1;
        tick_both(120, 1'b1);
        tick_both(40, 1'b1);
        tick_both(120, 1'b0);
        no_gaps = 1'b0;
    endtask

    task automatic test_basic_requests;
        configure(MM_PER_TICK_RESET, ANGLE_PER_TICK_RESET);
        send_request(CMD_LEFT, 1'b1);
        send_request(CMD_LEFT, 1'b0);
        send_request(CMD_RIGHT, 1'b1);
        send_request(CMD_RIGHT, 1'b1);
        send_request(CMD_UPDATE, 1'b1);
        send_request(CMD_IGNORED, 1'b1);
        send_request(CMD_UPDATE, 1'b0);
        send_request(CMD_RIGHT, 1'b0);
        send_request(CMD_RIGHT, 1'b0);
        send_request(CMD_LEFT, 1'b1);
        send_request(CMD_UPDATE, 1'b0);
    endtask

    // half-unit products round upward; odd wheel sums truncate towards zero
    task automatic test_rounding;
        configure(24'd128, 24'd128);
        send_request(CMD_LEFT, 1'b1);
        send_request(CMD_RIGHT, 1'b1);
        send_request(CMD_UPDATE, 1'b1);
        send_request(CMD_RIGHT, 1'b1);
        send_request(CMD_UPDATE, 1'b1);
        send_request(CMD_LEFT, 1'b0);
        send_request(CMD_RIGHT, 1'b0);
        send_request(CMD_UPDATE, 1'b0);
        send_request(CMD_LEFT, 1'b0);
        send_request(CMD_LEFT, 1'b0);
        send_request(CMD_RIGHT, 1'b0);
        send_request(CMD_UPDATE, 1'b1);
    endtask

    task automatic test_register_extremes;
        configure(24'hFF_FFFF, 24'hFF_FFFF);
        send_request(CMD_RIGHT, 1'b1);
        send_request(CMD_LEFT, 1'b0);
        send_request(CMD_UPDATE, 1'b1);
        configure(24'd0, 24'd0);
        send_request(CMD_RIGHT, 1'b1);
        send_request(CMD_UPDATE, 1'b0);
    endtask

    task automatic test_random_travel;
        int               counted;
        int               n;
        logic             up_l;
        logic             up_r;
        logic             sp;
        logic [CMD_W-1:0] w;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: configure(MM_PER_TICK_RESET, ANGLE_PER_TICK_RESET);
                1: configure(24'hFF_FFFF, CFG_W'($urandom_range(0, 24'hFF_FFFF)));
                2: configure(CFG_W'($urandom_range(0, 24'hFF_FFFF)), 24'hFF_FFFF);
                3: configure(CFG_W'($urandom_range(0, 24'hFF_FFFF)),
                             CFG_W'($urandom_range(0, 24'hFF_FFFF)));
                default: configure(CFG_W'($urandom_range(0, 4095)),
                                   CFG_W'($urandom_range(0, 24'hFF_FFFF)));
            endcase
            counted = 0;
            while (counted < PHASE_LEN)
            begin
                case ($urandom_range(0, 9))
                    8:
                    begin
                        repeat ($urandom_range(1, 6))
                        begin
                            w = CMD_W'($urandom_range(0, 3));
                            send_request(w, 1'($urandom_range(0, 1)));
                            if (w != CMD_IGNORED)
                                counted++;
                        end
                    end
                    9:
                    begin
                        repeat ($urandom_range(1, 3))
                        begin
                            send_request(CMD_UPDATE, 1'($urandom_range(0, 1)));
                            counted++;
                        end
                    end
                    default:
                    begin
                        n    = $urandom_range(0, 40);
                        up_l = 1'($urandom_range(0, 1));
                        up_r = 1'($urandom_range(0, 1));
                        repeat (n)
                        begin
                            w  = $urandom_range(0, 1) ? CMD_RIGHT : CMD_LEFT;
                            sp = (w == CMD_RIGHT) ? up_r : up_l;
                            if ($urandom_range(0, 9) == 0)
                                sp = !sp;
                            send_request(w, sp);
                        end
                        send_request(CMD_UPDATE, 1'($urandom_range(0, 1)));
                        counted += n + 1;
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        pose_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            pose_ch.ready = no_gaps || ($urandom_range(0, 2) != 0);
        end
    end

    always @(posedge clk)
    begin
        pose_t seen;
        pose_t want;
        if (rst_n && pose_ch.valid && pose_ch.ready)
        begin
            seen.pos_x       = pose_ch.pos_x;
            seen.pos_y       = pose_ch.pos_y;
            seen.heading     = pose_ch.heading;
            seen.left_total  = pose_ch.left_total;
            seen.right_total = pose_ch.right_total;
            if (poses_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected pose: x=%0d y=%0d heading=%0d left=%0d right=%0d",
                             seen.pos_x, seen.pos_y, seen.heading, seen.left_total,
                             seen.right_total);
            end
            else
            begin
                want = poses_due.pop_front();
                if (seen.pos_x !== want.pos_x || seen.pos_y !== want.pos_y ||
                    seen.heading !== want.heading || seen.left_total !== want.left_total ||
                    seen.right_total !== want.right_total)
                begin
                    faults++;
                    if (faults <= 10)
                        $display({"pose mismatch: expected x=%0d y=%0d heading=%0d left=%0d ",
                                  "right=%0d, got x=%0d y=%0d heading=%0d left=%0d right=%0d"},
                                 want.pos_x, want.pos_y, want.heading, want.left_total,
                                 want.right_total, seen.pos_x, seen.pos_y, seen.heading,
                                 seen.left_total, seen.right_total);
                end
            end
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = REG_MM_PER_TICK;
        cfg_data                  = '0;
        request_ch.valid          = 1'b0;
        request_ch.command        = CMD_LEFT;
        request_ch.speed_positive = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_long_runs;
        test_basic_requests;
        test_rounding;
        test_register_extremes;
        test_random_travel;

        wait_for_poses;
        if (faults == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_if.sv
hw/rtl/differential_drive_odometry.sv
dv/differential_drive_odometry_test.sv
